// File: design/dre_pkg.sv
`default_nettype none

package dre_pkg;

   // message limits and layout
   localparam int unsigned MAX_MESSAGE_BYTES = 65535;
   localparam int unsigned POS_W             = 17;
   localparam int unsigned HEADER_BYTES      = 12;
   localparam int unsigned QUESTION_TAIL     = 5;

   // answer record offsets, relative to the record start
   localparam int unsigned REL_TYPE_HI = 2;
   localparam int unsigned REL_TYPE_LO = 3;
   localparam int unsigned REL_LEN_HI  = 10;
   localparam int unsigned REL_LEN_LO  = 11;
   localparam int unsigned REL_ADDR_0  = 12;
   localparam int unsigned REL_ADDR_3  = 15;

   localparam logic [15:0] TYPE_A     = 16'd1;
   localparam logic [15:0] IPV4_BYTES = 16'd4;

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_NAME   = 4'b0010,
      PH_ANSWER = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] ipv4_address;
   } result_type;

endpackage

`default_nettype wire

// File: design/dre_if.sv
`default_nettype none

interface dre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dre_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] ipv4_address;

   modport source (output valid, output found, output ipv4_address, input ready);
   modport sink   (input valid, input found, input ipv4_address, output ready);
endinterface

`default_nettype wire

// File: design/dre_in_stage.sv
`default_nettype none

module dre_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire dre_pkg::byte_item_type in_item,
   output logic                        item_valid,
   output dre_pkg::byte_item_type      item,
   input  wire logic                   item_take
);
   import dre_pkg::*;

   logic          valid_ff, valid_in;
   byte_item_type item_ff;

   // free slot or the held item leaves this cycle
   assign in_ready = !valid_ff || item_take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: design/dre_parser.sv
`default_nettype none

module dre_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  wire dre_pkg::byte_item_type item,
   output logic                        item_take,
   input  wire logic                   out_free,
   output logic                        res_valid,
   output dre_pkg::result_type         result
);
   import dre_pkg::*;

   pos_type     pos_ff, pos_in;
   pos_type     label_ff, label_in;
   pos_type     ans_ff, ans_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] addr_ff, addr_in;
   logic        ovf_ff, ovf_in;

   pos_type     rel;
   logic        ok;

   // a last byte needs room in the result register
   assign item_take = item_valid && (!item.last || out_free);
   assign res_valid = item_take && item.last;
   assign rel       = pos_ff - ans_ff;

   always_comb begin
      pos_in   = pos_ff;
      label_in = label_ff;
      ans_in   = ans_ff;
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      ovf_in   = ovf_ff;

      if (pos_ff >= POS_W'(MAX_MESSAGE_BYTES)) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff >= POS_W'(HEADER_BYTES - 1)) begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (pos_ff == label_ff) begin
                  if (item.data_byte == 8'd0) begin
                     ans_in   = pos_ff + POS_W'(QUESTION_TAIL);
                     phase_in = PH_ANSWER;
                  end else begin
                     // compression pointers walk as plain lengths
                     label_in = label_ff + POS_W'(item.data_byte) + POS_W'(1);
                  end
               end
            end
            PH_ANSWER: begin
               if (pos_ff >= ans_ff) begin
                  if (rel == POS_W'(REL_TYPE_HI) || rel == POS_W'(REL_TYPE_LO)) begin
                     type_in = {type_ff[7:0], item.data_byte};
                  end else if (rel == POS_W'(REL_LEN_HI) || rel == POS_W'(REL_LEN_LO)) begin
                     len_in = {len_ff[7:0], item.data_byte};
                  end else if (rel >= POS_W'(REL_ADDR_0) && rel <= POS_W'(REL_ADDR_3)) begin
                     addr_in = {addr_ff[23:0], item.data_byte};
                     if (rel == POS_W'(REL_ADDR_3)) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            default: begin
               // done: trailing bytes ignored
            end
         endcase
      end
   end

   assign ok = (phase_in == PH_DONE) && !ovf_in && (type_in == TYPE_A) &&
               (len_in == IPV4_BYTES);
   assign result.found        = ok;
   assign result.ipv4_address = ok ? addr_in : 32'd0;

   always_ff @(posedge clock) begin
      if (reset || res_valid) begin
         pos_ff   <= '0;
         label_ff <= POS_W'(HEADER_BYTES);
         ans_ff   <= '0;
         phase_ff <= PH_HEADER;
         type_ff  <= '0;
         len_ff   <= '0;
         addr_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (item_take) begin
         pos_ff   <= pos_in;
         label_ff <= label_in;
         ans_ff   <= ans_in;
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// File: design/dre_out_stage.sv
`default_nettype none

module dre_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_valid,
   input  wire dre_pkg::result_type result,
   output logic                     out_free,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dre_pkg::result_type      out_result
);
   import dre_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || out_ready;
   assign valid_in = out_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// File: design/dns_response_ipv4_extractor_unit.sv
`default_nettype none

// channel   dir  items                      payload
// req_chan  in   message bytes, one a beat   data_byte[7:0], last
// rsp_chan  out  one per message, on last    found, ipv4_address[31:0]
//
// one byte accepted per cycle, sustained, save for the stall on a last byte below; a result is
// valid once its last byte has passed the input register and then the result register
// the parser updates its state as it takes each byte, between the two registers
// synchronous active-high reset clears the parser to the header phase
// a stalled result holds the result register; the parser then stalls only
// on the next last byte, ordinary bytes keep flowing

module dns_response_ipv4_extractor_unit (
   input  wire logic clock,
   input  wire logic reset,
   dre_req_if.sink   req_chan,
   dre_rsp_if.source rsp_chan
);
   import dre_pkg::*;

   byte_item_type in_item;
   byte_item_type item;
   logic          item_valid;
   logic          item_take;
   logic          out_free;
   logic          res_valid;
   result_type    result;
   result_type    out_result;

   assign in_item.data_byte = req_chan.data_byte;
   assign in_item.last      = req_chan.last;

   // input register
   dre_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // byte walker: header skip, name walk, answer capture
   dre_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .result     (result)
   );

   // result register
   dre_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .result     (result),
      .out_free   (out_free),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (out_result)
   );

   assign rsp_chan.found        = out_result.found;
   assign rsp_chan.ipv4_address = out_result.ipv4_address;

endmodule

`default_nettype wire

// File: dv/a_record_checker.sv
`timescale 1ns / 1ps

module a_record_checker (
   input  logic clock,
   input  logic reset,
   dre_req_if   req_mon,
   dre_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import dre_pkg::*;

   // shadow parser state
   pos_type     msg_pos;
   pos_type     label_pos;
   pos_type     rec_start;
   phase_type   phase;
   logic [15:0] rec_type;
   logic [15:0] rec_len;
   logic [31:0] addr_acc;
   logic        too_long;

   result_type  awaited_answers[$];

   task automatic clear_parse();
      msg_pos   = '0;
      label_pos = pos_type'(HEADER_BYTES);
      rec_start = '0;
      phase     = PH_HEADER;
      rec_type  = '0;
      rec_len   = '0;
      addr_acc  = '0;
      too_long  = 1'b0;
   endtask

   always @(posedge clock) begin : watch
      logic [7:0] b;
      pos_type    rel;
      result_type want;
      if (reset) begin
         clear_parse();
         awaited_answers.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_answers.size() == 0) begin
               $error("unexpected result: found %0b, ipv4_address %h",
                      rsp_mon.found, rsp_mon.ipv4_address);
               fail_count++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_mon.found);
                  fail_count++;
               end
               if (rsp_mon.ipv4_address !== want.ipv4_address) begin
                  $error("ipv4_address: expected %h, actual %h",
                         want.ipv4_address, rsp_mon.ipv4_address);
                  fail_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            b = req_mon.data_byte;
            if (msg_pos >= MAX_MESSAGE_BYTES) begin
               too_long = 1'b1;
            end else begin
               case (phase)
                  PH_HEADER: if (msg_pos + 1 >= HEADER_BYTES) phase = PH_NAME;
                  PH_NAME: if (msg_pos == label_pos) begin
                     // any nonzero byte, pointers included, is a length
                     if (b == 8'd0) begin
                        rec_start = pos_type'(msg_pos + QUESTION_TAIL);
                        phase     = PH_ANSWER;
                     end else begin
                        label_pos = pos_type'(label_pos + b + 1);
                     end
                  end
                  PH_ANSWER: if (msg_pos >= rec_start) begin
                     rel = msg_pos - rec_start;
                     if (rel == REL_TYPE_HI || rel == REL_TYPE_LO) begin
                        rec_type = {rec_type[7:0], b};
                     end else if (rel == REL_LEN_HI || rel == REL_LEN_LO) begin
                        rec_len = {rec_len[7:0], b};
                     end else if (rel >= REL_ADDR_0 && rel <= REL_ADDR_3) begin
                        addr_acc = {addr_acc[23:0], b};
                        if (rel == REL_ADDR_3) phase = PH_DONE;
                     end
                  end
                  default: ;
               endcase
               msg_pos = pos_type'(msg_pos + 1);
            end

            if (req_mon.last) begin
               want.found = (phase == PH_DONE) && !too_long &&
                            rec_type == TYPE_A && rec_len == IPV4_BYTES;
               want.ipv4_address = want.found ? addr_acc : 32'd0;
               awaited_answers.push_back(want);
               clear_parse();
            end
         end
      end
      pending = awaited_answers.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import dre_pkg::*;

   // long receiver hold-off, and how long the drain may take at the end
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 100000;
   // random part per idling phase
   localparam int PHASE_BYTES   = 160;
   localparam int PHASE_RESULTS = 4;

   logic clock = 1'b0;
   logic reset;

   dre_req_if req_chan ();
   dre_rsp_if rsp_chan ();

   int fail_count;
   int pending;

   // idling knobs, sender side is read only by the stimulus process
   int   tx_idle_pct = 21;
   int   rx_idle_pct = 73;
   logic squeeze     = 1'b0;

   int   bytes_sent  = 0;
   int   msgs_sent   = 0;

   // message under construction, sent front to back
   logic [7:0] msg_bytes[$];

   dns_response_ipv4_extractor_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   a_record_checker answer_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #4000000;
      $display("tb failed");
      $finish;
   end

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // offer one byte, with random idle cycles ahead of it, and wait for the handshake
   task automatic offer_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last      <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++) begin
         offer_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
      msgs_sent++;
   endtask

   // well-formed response: header, question name, question tail, one answer, n_extra trailing bytes
   task automatic compose_response(input int n_labels, input int max_label,
                                   input logic [15:0] rtype, input logic [15:0] rlen,
                                   input logic [31:0] addr, input int n_extra);
      int len;
      msg_bytes.delete();
      repeat (HEADER_BYTES) msg_bytes.push_back(rand_byte());
      for (int i = 0; i < n_labels; i++) begin
         len = $urandom_range(1, max_label);
         msg_bytes.push_back(len[7:0]);
         repeat (len) msg_bytes.push_back(rand_byte());
      end
      msg_bytes.push_back(8'h00);
      // question type and class
      repeat (4) msg_bytes.push_back(rand_byte());
      // answer name as a pointer
      msg_bytes.push_back(8'hc0);
      msg_bytes.push_back(8'h0c);
      msg_bytes.push_back(rtype[15:8]);
      msg_bytes.push_back(rtype[7:0]);
      // class and ttl
      repeat (6) msg_bytes.push_back(rand_byte());
      msg_bytes.push_back(rlen[15:8]);
      msg_bytes.push_back(rlen[7:0]);
      msg_bytes.push_back(addr[31:24]);
      msg_bytes.push_back(addr[23:16]);
      msg_bytes.push_back(addr[15:8]);
      msg_bytes.push_back(addr[7:0]);
      repeat (n_extra) msg_bytes.push_back(rand_byte());
   endtask

   // receiver: random ready, plus one long hold-off once squeeze goes high
   initial begin : receiver
      int   hold_left;
      logic squeeze_done;
      hold_left    = 0;
      squeeze_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (squeeze && !squeeze_done) begin
            rsp_chan.ready <= 1'b0;
            hold_left    = HOLD_CYCLES;
            squeeze_done = 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int kind;
      int n;
      int start_bytes;
      int start_msgs;
      int ph;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.last      <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // single-byte message
      msg_bytes.delete();
      msg_bytes.push_back(8'hff);
      send_message();
      // one byte short of a header
      msg_bytes.delete();
      repeat (11) msg_bytes.push_back(8'h00);
      send_message();
      // header only
      msg_bytes.delete();
      repeat (HEADER_BYTES) msg_bytes.push_back(8'hff);
      send_message();
      // shortest good answer, empty name, all-ones address
      compose_response(0, 1, TYPE_A, IPV4_BYTES, 32'hffff_ffff, 0);
      send_message();
      // one label of up to 63 bytes, zero address
      compose_response(1, 63, TYPE_A, IPV4_BYTES, 32'h0000_0000, 0);
      send_message();
      // right type, wrong length
      compose_response(2, 6, TYPE_A, 16'd5, rand_byte() << 8, 0);
      send_message();
      // wrong type, right length
      compose_response(1, 6, 16'd28, IPV4_BYTES, 32'h0a00_0001, 0);
      send_message();
      // both fields all ones
      compose_response(1, 6, 16'hffff, 16'hffff, 32'h8080_8080, 0);
      send_message();
      // answer cut just before the fourth address byte
      compose_response(2, 6, TYPE_A, IPV4_BYTES, 32'h7f00_0001, 0);
      void'(msg_bytes.pop_back());
      send_message();
      // compression pointer as a length jumps past the end of the message
      compose_response(1, 6, TYPE_A, IPV4_BYTES, 32'hc0a8_0101, 0);
      msg_bytes[HEADER_BYTES] = 8'hc0;
      send_message();
      // trailing bytes after the address are ignored
      compose_response(3, 6, TYPE_A, IPV4_BYTES, 32'h0102_0304, 5);
      send_message();

      // ---- random part, three idling phases ----
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 21;
               rx_idle_pct <= 73;
            end
            1: begin
               tx_idle_pct = 73;
               rx_idle_pct <= 21;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
               // long receiver stall while the sender keeps going
               squeeze <= 1'b1;
            end
         endcase
         start_bytes = bytes_sent;
         start_msgs  = msgs_sent;
         while (bytes_sent - start_bytes < PHASE_BYTES ||
                msgs_sent - start_msgs < PHASE_RESULTS) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
               // mostly valid a records with random content
               compose_response($urandom_range(0, 3), 6,
                                ($urandom_range(4) != 0) ? TYPE_A : {rand_byte(), rand_byte()},
                                ($urandom_range(4) != 0) ? IPV4_BYTES : {rand_byte(), rand_byte()},
                                $urandom, ($urandom_range(1) != 0) ? $urandom_range(1, 3) : 0);
            end else if (kind < 75) begin
               // truncated somewhere inside
               compose_response($urandom_range(0, 2), 6, TYPE_A, IPV4_BYTES, $urandom, 0);
               n = $urandom_range(1, msg_bytes.size() - 1);
               while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
            end else if (kind < 85) begin
               // first length byte overshoots
               compose_response($urandom_range(0, 2), 6, TYPE_A, IPV4_BYTES, $urandom, 0);
               msg_bytes[HEADER_BYTES] = 8'($urandom_range(64, 255));
            end else begin
               // plain noise
               msg_bytes.delete();
               repeat ($urandom_range(1, 40)) msg_bytes.push_back(rand_byte());
            end
            send_message();
         end
      end

      // ---- drain ----
      req_chan.valid <= 1'b0;
      n = 0;
      while (pending != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/dre_pkg.sv
design/dre_if.sv
design/dre_in_stage.sv
design/dre_parser.sv
design/dre_out_stage.sv
design/dns_response_ipv4_extractor_unit.sv
dv/a_record_checker.sv
dv/tb.sv
